/* src/pwml_pkg.sv */
// Shared constants for the prime window minimum length block.
package pwml_pkg;

  localparam int FIELD_W  = 16;
  localparam int RESULT_W = 17;

  localparam logic [RESULT_W-1:0] RESULT_NONE = {RESULT_W{1'b1}};

endpackage

/* src/prime_window_min_length.sv */
// Top level: sieve, prefix-count table and windowed binary-search query engine.
//
// After reset the block builds its tables before it takes the first query: a
// clearing pass over every value up to MAX_VALUE, a sieve over candidates up
// to sqrt(MAX_VALUE) that strikes each prime's multiples from its square, then
// a prefix-count fill. in_ready stays low until then. A query runs a binary
// search over the window length; each pass checks the windows in turn and
// stops at the first failing window, and every window check reads the
// dual-read prefix-count memory once. The worst case at the default is roughly
// 17 passes of up to 65536 windows; one query is in flight at a time. The
// result is held on shortest_length until out_ready, and all ones (-1) means
// the query is out of range or no window length qualifies.
module prime_window_min_length #(
  parameter int MAX_VALUE = 65535
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [pwml_pkg::FIELD_W-1:0]      query_low,
  input  logic [pwml_pkg::FIELD_W-1:0]      query_high,
  input  logic [pwml_pkg::FIELD_W-1:0]      min_primes,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [pwml_pkg::RESULT_W-1:0] shortest_length
);
  import pwml_pkg::*;

  localparam int AW = $clog2(MAX_VALUE + 2);
  localparam int FW = $clog2(MAX_VALUE + 1);
  localparam int CW = AW;
  localparam int QW = ((AW > FIELD_W) ? AW : FIELD_W) + 1;
  localparam int DW = (CW > FIELD_W) ? CW : FIELD_W;

  typedef enum logic [3:0] {
    S_CLR, S_PRD, S_PCHK, S_MARK, S_FRD, S_FWR,
    S_IDLE, S_MID, S_SCAN, S_OUT
  } state_t;

  state_t state;

  logic          flags  [0:MAX_VALUE];
  logic [CW-1:0] prefix [0:MAX_VALUE+1];

  logic [AW:0]   cnt;
  logic [AW-1:0] p;
  logic [AW:0]   psq;
  logic [CW-1:0] acc;

  logic          flag_rd;
  logic [CW-1:0] pa_rd, pb_rd;

  logic [QW-1:0] lo, hi, left, right, mid, s, best;
  logic [FIELD_W-1:0] need;
  logic          found;
  logic          iv;
  logic [RESULT_W-1:0] res;

  logic          f_we, f_wd;
  logic [FW-1:0] f_wa, f_ra;
  logic          p_we;
  logic [AW-1:0] p_wa, p_ra0, p_ra1;
  logic [CW-1:0] p_wd;

  logic [QW:0]   win_end;
  logic          issuing;
  logic [CW-1:0] diff;
  logic          fail;
  logic [CW-1:0] acc_next;
  logic [QW-1:0] mid_next;
  logic          q_ok;

  assign win_end  = {1'b0, s} + {1'b0, mid};
  assign issuing  = win_end <= ({1'b0, hi} + 1'b1);
  assign diff     = pb_rd - pa_rd;
  assign fail     = iv && (DW'(diff) < DW'(need));
  assign acc_next = acc + CW'(flag_rd);
  assign mid_next = left + ((right - left) >> 1);
  assign q_ok     = (query_low <= query_high) &&
                    (32'(query_high) <= 32'(MAX_VALUE)) &&
                    (32'(query_low) <= 32'(MAX_VALUE));

  always_comb begin
    f_we  = 1'b0;
    f_wd  = 1'b0;
    f_wa  = cnt[FW-1:0];
    f_ra  = (state == S_PRD) ? p[FW-1:0] : cnt[FW-1:0];
    p_we  = 1'b0;
    p_wa  = cnt[AW-1:0];
    p_wd  = '0;
    p_ra0 = s[AW-1:0];
    p_ra1 = win_end[AW-1:0];
    case (state)
      S_CLR: begin
        // 0 and 1 are not prime
        f_we = 1'b1;
        f_wd = (cnt[AW:1] != '0);
        p_we = 1'b1;
      end
      S_MARK: begin
        f_we = 1'b1;
      end
      S_FWR: begin
        p_we = 1'b1;
        p_wa = AW'(cnt + 1'b1);
        p_wd = acc_next;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (f_we) flags[f_wa] <= f_wd;
    flag_rd <= flags[f_ra];
  end

  always_ff @(posedge clk) begin
    if (p_we) prefix[p_wa] <= p_wd;
    pa_rd <= prefix[p_ra0];
    pb_rd <= prefix[p_ra1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      cnt       <= '0;
      iv        <= 1'b0;
      in_ready  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          if (cnt == (AW+1)'(MAX_VALUE)) begin
            p     <= AW'(2);
            psq   <= (AW+1)'(4);
            state <= S_PRD;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_PRD: begin
          if (psq > (AW+1)'(MAX_VALUE)) begin
            cnt   <= '0;
            acc   <= '0;
            state <= S_FRD;
          end else begin
            state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (flag_rd) begin
            cnt   <= psq;
            state <= S_MARK;
          end else begin
            p     <= p + 1'b1;
            psq   <= psq + {p, 1'b0} + 1'b1;
            state <= S_PRD;
          end
        end
        S_MARK: begin
          if ((cnt + (AW+1)'(p)) > (AW+1)'(MAX_VALUE)) begin
            p     <= p + 1'b1;
            psq   <= psq + {p, 1'b0} + 1'b1;
            state <= S_PRD;
          end else begin
            cnt <= cnt + (AW+1)'(p);
          end
        end
        S_FRD: begin
          state <= S_FWR;
        end
        S_FWR: begin
          acc <= acc_next;
          if (cnt == (AW+1)'(MAX_VALUE)) begin
            in_ready <= 1'b1;
            state    <= S_IDLE;
          end else begin
            cnt   <= cnt + 1'b1;
            state <= S_FRD;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            in_ready <= 1'b0;
            lo       <= QW'(query_low);
            hi       <= QW'(query_high);
            need     <= min_primes;
            found    <= 1'b0;
            left     <= QW'(1);
            right    <= QW'(query_high) - QW'(query_low) + 1'b1;
            if (q_ok) begin
              state <= S_MID;
            end else begin
              res       <= RESULT_NONE;
              out_valid <= 1'b1;
              state     <= S_OUT;
            end
          end
        end
        S_MID: begin
          if (left > right) begin
            res       <= found ? best[RESULT_W-1:0] : RESULT_NONE;
            out_valid <= 1'b1;
            state     <= S_OUT;
          end else begin
            mid   <= mid_next;
            s     <= lo;
            iv    <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (fail) begin
            left  <= mid + 1'b1;
            iv    <= 1'b0;
            state <= S_MID;
          end else if (!issuing && !iv) begin
            best  <= mid;
            found <= 1'b1;
            right <= mid - 1'b1;
            state <= S_MID;
          end else begin
            iv <= issuing;
            if (issuing) s <= s + 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

  assign shortest_length = res;

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> (mid >= left && mid <= right))
    else $error("search length outside the search bounds");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_MID || $past(state) == S_IDLE))
    else $error("result raised outside a query");

  a_scan_window: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && issuing) |-> ({1'b0, s} + {1'b0, mid} <= {1'b0, hi} + 1'b1
                                      && s >= lo))
    else $error("window read outside the interval");

endmodule
